### design/kt_pkg.sv
// Package for the key table: entry layout, operation codes, default sizes.
// No dependencies; imported by every module of the key table.
`timescale 1ns / 1ps

package kt_pkg;

	localparam int ENTRIES_DEF = 4;

	localparam logic KIND_LOOKUP = 1'b0;
	localparam logic KIND_ADD    = 1'b1;

	typedef struct packed {
		logic [15:0] diversifier;
		logic [63:0] random_value;
		logic [63:0] key_high;
		logic [63:0] key_low;
		logic        authenticated;
	} entry_t;

	typedef struct packed {
		logic add;
		logic lookup;
		logic issue;
		logic capture;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic left_zero;
		logic hit;
		logic last;
		logic out_free;
	} sts_t;

endpackage

### design/kt_ctrl.sv
// Controller state machine of the key table: accepts beats, sequences the scan.
// Depends on kt_pkg for the command and status structs and operation codes.
`timescale 1ns / 1ps

module kt_ctrl import kt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  logic kind,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					if (kind == KIND_ADD) begin
						cmd.add = 1'b1;
					end else begin
						cmd.lookup = 1'b1;
						if (sts.count_zero) begin
							cmd.capture = 1'b1;
							state_d     = ST_RESP;
						end else begin
							state_d = ST_SCAN;
						end
					end
				end
			end
			ST_SCAN: begin
				cmd.issue = !sts.left_zero;
				if (sts.hit || sts.last) begin
					cmd.capture = 1'b1;
					state_d     = ST_RESP;
				end
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### design/kt_datapath.sv
// Datapath of the key table: circular entry memory, pointers, compare and
// result registers. Depends on kt_pkg; driven by kt_ctrl through cmd_t/sts_t.
`timescale 1ns / 1ps

module kt_datapath import kt_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [15:0] diversifier,
	input  logic [63:0] random_value,
	input  logic [63:0] key_high,
	input  logic [63:0] key_low,
	input  logic        authenticated,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        found,
	output logic [63:0] match_key_high,
	output logic [63:0] match_key_low,
	output logic        match_authenticated
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] r;
		if (idx == LAST_IDX) begin
			r = '0;
		end else begin
			r = idx + IDX_W'(1);
		end
		return r;
	endfunction

	entry_t           mem [ENTRIES];
	entry_t           rd_data_s1;
	logic             rd_vld_s1;
	logic             rd_last_s1;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [IDX_W-1:0] scan_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] left_q;
	logic [15:0]      div_q;
	logic [63:0]      rnd_q;
	logic             res_found_q;
	logic [63:0]      res_kh_q;
	logic [63:0]      res_kl_q;
	logic             res_auth_q;
	logic             rsp_valid_q;
	logic             found_q;
	logic [63:0]      match_kh_q;
	logic [63:0]      match_kl_q;
	logic             match_auth_q;
	logic             hit;
	entry_t           wr_entry;

	assign wr_entry = '{diversifier: diversifier, random_value: random_value,
		key_high: key_high, key_low: key_low, authenticated: authenticated};

	always_ff @(posedge clk) begin
		if (cmd.add) begin
			mem[tail_q] <= wr_entry;
		end
		if (cmd.issue) begin
			rd_data_s1 <= mem[scan_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			scan_ptr_q  <= '0;
			left_q      <= '0;
			rd_vld_s1   <= 1'b0;
			rd_last_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_s1  <= cmd.issue;
			rd_last_s1 <= cmd.issue && (left_q == CNT_W'(1));
			if (cmd.add) begin
				tail_q <= next_idx(tail_q);
				if (count_q == FULL_CNT) begin
					head_q <= next_idx(head_q);
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.lookup) begin
				scan_ptr_q <= head_q;
				left_q     <= count_q;
			end else if (cmd.issue) begin
				scan_ptr_q <= next_idx(scan_ptr_q);
				left_q     <= left_q - CNT_W'(1);
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign hit = rd_vld_s1 && (rd_data_s1.diversifier == div_q)
		&& (rd_data_s1.random_value == rnd_q);

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			div_q <= diversifier;
			rnd_q <= random_value;
		end
		if (cmd.capture) begin
			res_found_q <= hit;
			res_kh_q    <= hit ? rd_data_s1.key_high : '0;
			res_kl_q    <= hit ? rd_data_s1.key_low : '0;
			res_auth_q  <= hit && rd_data_s1.authenticated;
		end
		if (cmd.out_load) begin
			found_q      <= res_found_q;
			match_kh_q   <= res_kh_q;
			match_kl_q   <= res_kl_q;
			match_auth_q <= res_auth_q;
		end
	end

	assign sts.count_zero = (count_q == '0);
	assign sts.left_zero  = (left_q == '0);
	assign sts.hit        = hit;
	assign sts.last       = rd_vld_s1 && rd_last_s1;
	assign sts.out_free   = !rsp_valid_q || !rsp_stall;

	assign rsp_valid           = rsp_valid_q;
	assign found               = found_q;
	assign match_key_high      = match_kh_q;
	assign match_key_low       = match_kl_q;
	assign match_authenticated = match_auth_q;

endmodule

### design/key_table_fifo_evict_lookup.sv
// Associative key table with oldest-first replacement: up to ENTRIES keys,
// matched on diversifier and random number. An add beat gives no response;
// when the table is full the oldest entry is overwritten.
// A lookup beat scans the entries oldest first, one memory read per cycle on
// the single read port, and returns the oldest match: the result is captured
// when the first match, or the last entry on a miss, is read, or at once when
// the table is empty, and is then loaded into the response register once that
// register is free of a response held by rsp_stall; the next request is taken
// in the cycle after the load. No clearing pass after reset.
// Depends on kt_pkg, kt_ctrl and kt_datapath.
`timescale 1ns / 1ps

module key_table_fifo_evict_lookup import kt_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        kind,
	input  logic [15:0] diversifier,
	input  logic [63:0] random_value,
	input  logic [63:0] key_high,
	input  logic [63:0] key_low,
	input  logic        authenticated,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        found,
	output logic [63:0] match_key_high,
	output logic [63:0] match_key_low,
	output logic        match_authenticated
);

	cmd_t cmd;
	sts_t sts;

	kt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.kind      (kind),
		.sts       (sts),
		.cmd       (cmd)
	);

	kt_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.diversifier         (diversifier),
		.random_value        (random_value),
		.key_high            (key_high),
		.key_low             (key_low),
		.authenticated       (authenticated),
		.rsp_valid           (rsp_valid),
		.rsp_stall           (rsp_stall),
		.found               (found),
		.match_key_high      (match_key_high),
		.match_key_low       (match_key_low),
		.match_authenticated (match_authenticated)
	);

	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && kind == KIND_LOOKUP) |=> req_stall)
		else $error("lookup accepted but request side not stalled");

	a_rsp_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd.out_load))
		else $error("response raised without a load");

	a_issue_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> !sts.left_zero)
		else $error("memory read issued past the entry count");

	a_single_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.add, cmd.lookup, cmd.issue, cmd.out_load}))
		else $error("conflicting datapath commands");

endmodule

### sim/key_table_lookup_checker.sv
// Checker for the key table: watches both channels, keeps its own copy of the table,
// predicts every lookup response and compares it field by field. Depends on kt_pkg.
`timescale 1ns / 1ps

module key_table_lookup_checker import kt_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic        kind,
	input  logic [15:0] diversifier,
	input  logic [63:0] random_value,
	input  logic [63:0] key_high,
	input  logic [63:0] key_low,
	input  logic        authenticated,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic        found,
	input  logic [63:0] match_key_high,
	input  logic [63:0] match_key_low,
	input  logic        match_authenticated,
	output int          fail_count,
	output int          lookups_in_flight
);

	typedef struct packed {
		logic        found;
		logic [63:0] key_high;
		logic [63:0] key_low;
		logic        authenticated;
	} lookup_result_t;

	entry_t         stored [ENTRIES];
	int unsigned    entry_count;
	lookup_result_t pending_lookups [$];
	int             mismatches = 0;

	assign fail_count = mismatches;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	function automatic lookup_result_t oldest_match(input logic [15:0] div,
			input logic [63:0] rnd);
		lookup_result_t res;
		res = '0;
		for (int p = 0; p < ENTRIES; p++) begin
			if (p < entry_count && !res.found && stored[p].diversifier == div &&
					stored[p].random_value == rnd) begin
				res.found         = 1'b1;
				res.key_high      = stored[p].key_high;
				res.key_low       = stored[p].key_low;
				res.authenticated = stored[p].authenticated;
			end
		end
		return res;
	endfunction

	task automatic store_entry(input entry_t fresh);
		if (entry_count == ENTRIES) begin
			for (int p = 0; p < ENTRIES - 1; p++)
				stored[p] = stored[p + 1];
			entry_count = ENTRIES - 1;
		end
		stored[entry_count] = fresh;
		entry_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		lookup_result_t want;
		entry_t         fresh;
		if (!arst_n) begin
			entry_count = 0;
			pending_lookups.delete();
			lookups_in_flight <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_lookups.size() == 0) begin
					report_mismatch("response beat with no lookup outstanding", 64'(found),
						64'd0);
				end else begin
					want = pending_lookups.pop_front();
					if (found !== want.found)
						report_mismatch("found", 64'(found), 64'(want.found));
					if (match_key_high !== want.key_high)
						report_mismatch("match_key_high", match_key_high, want.key_high);
					if (match_key_low !== want.key_low)
						report_mismatch("match_key_low", match_key_low, want.key_low);
					if (match_authenticated !== want.authenticated)
						report_mismatch("match_authenticated", 64'(match_authenticated),
							64'(want.authenticated));
				end
			end
			if (req_valid && !req_stall) begin
				if (kind == KIND_ADD) begin
					fresh.diversifier   = diversifier;
					fresh.random_value  = random_value;
					fresh.key_high      = key_high;
					fresh.key_low       = key_low;
					fresh.authenticated = authenticated;
					store_entry(fresh);
				end else begin
					pending_lookups.push_back(oldest_match(diversifier, random_value));
				end
			end
			lookups_in_flight <= pending_lookups.size();
		end
	end

endmodule

### sim/tb_key_table_fifo_evict_lookup.sv
// Testbench top for the key table: drives add and lookup beats, throttles responses,
// and gives the verdict. Depends on kt_pkg, the key table and key_table_lookup_checker.
`timescale 1ns / 1ps

module tb_key_table_fifo_evict_lookup;
	import kt_pkg::*;

	localparam logic [63:0] ONES = '1;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        req_valid     = 1'b0;
	logic        kind          = KIND_LOOKUP;
	logic [15:0] diversifier   = '0;
	logic [63:0] random_value  = '0;
	logic [63:0] key_high      = '0;
	logic [63:0] key_low       = '0;
	logic        authenticated = 1'b0;
	logic        rsp_stall     = 1'b0;
	logic        req_stall;
	logic        rsp_valid;
	logic        found;
	logic [63:0] match_key_high;
	logic [63:0] match_key_low;
	logic        match_authenticated;

	int          fail_count;
	int          lookups_in_flight;
	bit          hold_off_go   = 1'b0;
	bit          hold_off_done = 1'b0;
	bit          no_idle       = 1'b0;
	logic [15:0] pool_div [8];
	logic [63:0] pool_rnd [8];

	key_table_fifo_evict_lookup DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.req_valid           (req_valid),
		.req_stall           (req_stall),
		.kind                (kind),
		.diversifier         (diversifier),
		.random_value        (random_value),
		.key_high            (key_high),
		.key_low             (key_low),
		.authenticated       (authenticated),
		.rsp_valid           (rsp_valid),
		.rsp_stall           (rsp_stall),
		.found               (found),
		.match_key_high      (match_key_high),
		.match_key_low       (match_key_low),
		.match_authenticated (match_authenticated)
	);

	key_table_lookup_checker CHK (
		.clk                 (clk),
		.arst_n              (arst_n),
		.req_valid           (req_valid),
		.req_stall           (req_stall),
		.kind                (kind),
		.diversifier         (diversifier),
		.random_value        (random_value),
		.key_high            (key_high),
		.key_low             (key_low),
		.authenticated       (authenticated),
		.rsp_valid           (rsp_valid),
		.rsp_stall           (rsp_stall),
		.found               (found),
		.match_key_high      (match_key_high),
		.match_key_low       (match_key_low),
		.match_authenticated (match_authenticated),
		.fail_count          (fail_count),
		.lookups_in_flight   (lookups_in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[key_table_fifo_evict_lookup] ERROR");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 15);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// hold the beat until accepted, then idle for a random gap (none while no_idle is set)
	task automatic offer_beat(input logic k, input logic [15:0] div, input logic [63:0] rnd,
			input logic [63:0] kh, input logic [63:0] kl, input logic auth);
		int gap;
		kind          <= k;
		diversifier   <= div;
		random_value  <= rnd;
		key_high      <= kh;
		key_low       <= kl;
		authenticated <= auth;
		req_valid     <= 1'b1;
		do @(posedge clk); while (req_stall);
		gap = no_idle ? 0 : idle_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_lookups();
		req_valid <= 1'b0;
		do @(posedge clk); while (lookups_in_flight != 0);
	endtask

	task automatic random_beat();
		logic        k;
		logic [15:0] div;
		logic [63:0] rnd;
		int          slot;
		int          pick;
		int          bit_pos;
		k    = ($urandom_range(0, 99) < 45) ? KIND_ADD : KIND_LOOKUP;
		slot = $urandom_range(0, 7);
		div  = pool_div[slot];
		rnd  = pool_rnd[slot];
		pick = $urandom_range(0, 99);
		if (k == KIND_ADD) begin
			if (pick < 20) begin
				div = 16'($urandom);
				rnd = rand64();
			end
		end else if (pick < 10) begin
			if ($urandom_range(0, 1)) begin
				bit_pos      = $urandom_range(0, 15);
				div[bit_pos] = ~div[bit_pos];
			end else
				rnd = rnd ^ (64'd1 << $urandom_range(0, 63));
		end else if (pick < 30) begin
			div = 16'($urandom);
			rnd = rand64();
		end
		offer_beat(k, div, rnd, rand64(), rand64(), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_go && !hold_off_done) begin
				rsp_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_off_done = 1'b1;
			end else if (no_idle || stall_left == 0) begin
				rsp_stall <= 1'b0;
				if (!no_idle)
					stall_left = idle_len();
			end else begin
				rsp_stall <= 1'b1;
				stall_left--;
			end
		end
	end

	initial begin
		int s;
		pool_div[0] = '0;
		pool_rnd[0] = '0;
		pool_div[1] = '1;
		pool_rnd[1] = ONES;
		for (s = 2; s < 8; s++) begin
			pool_div[s] = 16'($urandom);
			pool_rnd[s] = rand64();
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_beat(KIND_LOOKUP, 16'h0000, 64'd0, 64'd0, 64'd0, 1'b0);
		offer_beat(KIND_LOOKUP, 16'hffff, ONES, ONES, ONES, 1'b1);
		offer_beat(KIND_ADD, 16'h0000, 64'd0, 64'd0, 64'd0, 1'b0);
		offer_beat(KIND_LOOKUP, 16'h0000, 64'd0, ONES, ONES, 1'b1);
		offer_beat(KIND_ADD, 16'hffff, ONES, ONES, ONES, 1'b1);
		offer_beat(KIND_LOOKUP, 16'hffff, ONES, 64'd0, 64'd0, 1'b0);
		offer_beat(KIND_LOOKUP, 16'hffff, 64'd0, 64'd0, 64'd0, 1'b0);
		offer_beat(KIND_LOOKUP, 16'h0000, ONES, 64'd0, 64'd0, 1'b0);
		offer_beat(KIND_ADD, 16'h0000, 64'd0, 64'h0123_4567_89ab_cdef,
			64'hfedc_ba98_7654_3210, 1'b1);
		offer_beat(KIND_LOOKUP, 16'h0000, 64'd0, 64'd0, 64'd0, 1'b0);
		offer_beat(KIND_ADD, 16'h5a5a, 64'ha5a5_a5a5_5a5a_5a5a, 64'h5555_5555_5555_5555,
			64'haaaa_aaaa_aaaa_aaaa, 1'b0);
		offer_beat(KIND_LOOKUP, 16'h5a5a, 64'ha5a5_a5a5_5a5a_5a5a, 64'd0, 64'd0, 1'b0);
		offer_beat(KIND_ADD, 16'h0001, 64'd1, 64'd1, 64'd1, 1'b1);
		offer_beat(KIND_LOOKUP, 16'h0000, 64'd0, 64'd0, 64'd0, 1'b0);
		offer_beat(KIND_ADD, 16'h8000, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
			64'd0, 1'b0);
		offer_beat(KIND_LOOKUP, 16'hffff, ONES, 64'd0, 64'd0, 1'b0);
		offer_beat(KIND_ADD, 16'h7fff, 64'h7fff_ffff_ffff_ffff, 64'd0, ONES, 1'b1);
		offer_beat(KIND_LOOKUP, 16'h0000, 64'd0, 64'd0, 64'd0, 1'b0);
		offer_beat(KIND_LOOKUP, 16'h7fff, 64'h7fff_ffff_ffff_ffff, 64'd0, 64'd0, 1'b0);
		offer_beat(KIND_LOOKUP, 16'h0001, 64'd1, 64'd0, 64'd0, 1'b0);
		drain_lookups();

		for (int n = 0; n < 1200; n++) begin
			if (n == 100)
				hold_off_go = 1'b1;
			no_idle = (n >= 500 && n < 650);
			if (n % 300 == 299)
				drain_lookups();
			if ($urandom_range(0, 49) == 0) begin
				s = $urandom_range(0, 7);
				pool_div[s] = 16'($urandom);
				pool_rnd[s] = rand64();
			end
			random_beat();
		end
		drain_lookups();
		repeat (40) @(posedge clk);

		if (fail_count == 0)
			$display("[key_table_fifo_evict_lookup] OK");
		else
			$display("[key_table_fifo_evict_lookup] ERROR");
		$finish;
	end

endmodule
